// File: sv/sdm_pkg.sv
// sdm_pkg: shared types and constants of the signed divide / remainder block
// used by sdm_prep, sdm_cell, sdm_post and signed_div_mod_64_checked_top
`default_nettype none

package sdm_pkg;

   localparam int unsigned OUT_W = 64;

   localparam logic REQ_QUOT = 1'b0;
   localparam logic REQ_REM  = 1'b1;

   typedef struct packed {
      logic rem_req;
      logic neg_a;
      logic neg_q;
      logic err;
   } sdm_flags_type;

endpackage

`default_nettype wire

// File: sv/sdm_prep.sv
// sdm_prep: input stage, takes magnitudes of the operands and flags the error cases
// depends on sdm_pkg
`default_nettype none

module sdm_prep #(
   parameter int unsigned DATA_WIDTH = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            adv,
   input  wire logic                            in_valid,
   input  wire logic                            in_type,
   input  wire logic [sdm_pkg::OUT_W-1:0]       in_dividend,
   input  wire logic [sdm_pkg::OUT_W-1:0]       in_divisor,
   output logic                                 out_valid,
   output sdm_pkg::sdm_flags_type               out_flags,
   output logic [DATA_WIDTH-1:0]                out_ma,
   output logic [DATA_WIDTH-1:0]                out_mb
);

   logic [DATA_WIDTH-1:0]  a;
   logic [DATA_WIDTH-1:0]  b;
   logic                   valid_ff;
   sdm_pkg::sdm_flags_type flags_ff, flags_in;
   logic [DATA_WIDTH-1:0]  ma_ff, ma_in;
   logic [DATA_WIDTH-1:0]  mb_ff, mb_in;

   always_comb begin
      a = in_dividend[DATA_WIDTH-1:0];
      b = in_divisor[DATA_WIDTH-1:0];
      flags_in.rem_req = (in_type == sdm_pkg::REQ_REM);
      flags_in.neg_a   = a[DATA_WIDTH-1];
      flags_in.neg_q   = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
      flags_in.err     = (b == {DATA_WIDTH{1'b0}})
                         || ((a == {1'b1, {(DATA_WIDTH-1){1'b0}}}) && (&b));
      ma_in = a[DATA_WIDTH-1] ? ({DATA_WIDTH{1'b0}} - a) : a;
      mb_in = b[DATA_WIDTH-1] ? ({DATA_WIDTH{1'b0}} - b) : b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         flags_ff <= flags_in;
         ma_ff    <= ma_in;
         mb_ff    <= mb_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_ma    = ma_ff;
   assign out_mb    = mb_ff;

endmodule

`default_nettype wire

// File: sv/sdm_cell.sv
// sdm_cell: one restoring division step, produces one quotient bit per cycle while adv is high
// depends on sdm_pkg
`default_nettype none

module sdm_cell #(
   parameter int unsigned DATA_WIDTH = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   adv,
   input  wire logic                   in_valid,
   input  wire sdm_pkg::sdm_flags_type in_flags,
   input  wire logic [DATA_WIDTH-1:0]  in_rem,
   input  wire logic [DATA_WIDTH-1:0]  in_dq,
   input  wire logic [DATA_WIDTH-1:0]  in_mb,
   output logic                        out_valid,
   output sdm_pkg::sdm_flags_type      out_flags,
   output logic [DATA_WIDTH-1:0]       out_rem,
   output logic [DATA_WIDTH-1:0]       out_dq,
   output logic [DATA_WIDTH-1:0]       out_mb
);

   logic [DATA_WIDTH:0]    shifted;
   logic [DATA_WIDTH:0]    diff;
   logic                   ge;
   logic                   valid_ff;
   sdm_pkg::sdm_flags_type flags_ff;
   logic [DATA_WIDTH-1:0]  rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]  dq_ff, dq_in;
   logic [DATA_WIDTH-1:0]  mb_ff;

   always_comb begin
      shifted = {in_rem, in_dq[DATA_WIDTH-1]};
      diff    = shifted - {1'b0, in_mb};
      ge      = ~diff[DATA_WIDTH];
      rem_in  = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      dq_in   = {in_dq[DATA_WIDTH-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         flags_ff <= in_flags;
         rem_ff   <= rem_in;
         dq_ff    <= dq_in;
         mb_ff    <= in_mb;
      end
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_rem   = rem_ff;
   assign out_dq    = dq_ff;
   assign out_mb    = mb_ff;

endmodule

`default_nettype wire

// File: sv/sdm_post.sv
// sdm_post: sign fix-up, error zeroing and a two-entry response queue
// depends on sdm_pkg
`default_nettype none

module sdm_post #(
   parameter int unsigned DATA_WIDTH = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire sdm_pkg::sdm_flags_type        in_flags,
   input  wire logic [DATA_WIDTH-1:0]         in_rem,
   input  wire logic [DATA_WIDTH-1:0]         in_quo,
   input  wire logic                          rsp_stall,
   output logic                               adv,
   output logic                               rsp_valid,
   output logic signed [sdm_pkg::OUT_W-1:0]   rsp_result_value,
   output logic                               rsp_range_error
);

   logic [DATA_WIDTH-1:0]        res;
   logic signed [DATA_WIDTH-1:0] res_s;
   logic [sdm_pkg::OUT_W-1:0]    res_ext;
   logic                         push;
   logic                         pop;
   logic [sdm_pkg::OUT_W-1:0]    val_ff [2];
   logic                         err_ff [2];
   logic                         wr_ptr_ff, wr_ptr_in;
   logic                         rd_ptr_ff, rd_ptr_in;
   logic [1:0]                   cnt_ff, cnt_in;

   always_comb begin
      if (in_flags.err) begin
         res = {DATA_WIDTH{1'b0}};
      end else if (in_flags.rem_req) begin
         res = in_flags.neg_a ? ({DATA_WIDTH{1'b0}} - in_rem) : in_rem;
      end else begin
         res = in_flags.neg_q ? ({DATA_WIDTH{1'b0}} - in_quo) : in_quo;
      end
      res_s   = $signed(res);
      res_ext = sdm_pkg::OUT_W'(res_s);
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign adv       = (cnt_ff != 2'd2) || !rsp_stall;
   assign push      = adv && in_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         val_ff[wr_ptr_ff] <= res_ext;
         err_ff[wr_ptr_ff] <= in_flags.err;
      end
   end

   assign rsp_result_value = $signed(val_ff[rd_ptr_ff]);
   assign rsp_range_error  = err_ff[rd_ptr_ff];

   // queue never holds more than two requests
   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("response queue count out of range");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |-> (rsp_result_value == '0))
      else $error("flagged response carries nonzero value");

   a_reset_empty: assert property (@(posedge clock) reset |=> (cnt_ff == 2'd0))
      else $error("queue not empty after reset");

   a_adv_room: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 2'd2) |-> adv)
      else $error("pipeline held while queue has room");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |-> !push)
      else $error("push into full queue");

endmodule

`default_nettype wire

// File: sv/signed_div_mod_64_checked_top.sv
// signed_div_mod_64_checked_top: pipelined signed divide / remainder with range check
// path: a request passes the sdm_prep register, the sdm_cell registers and the sdm_post response queue in that order
// throughput: one request per cycle while req_stall is low, one quotient bit per cell in a chain of DATA_WIDTH cells
// a two-entry response queue lets requests flow while a response waits
// reset: synchronous active high, empties the pipeline and the queue
// depends on sdm_pkg, sdm_prep, sdm_cell, sdm_post
`default_nettype none

module signed_div_mod_64_checked_top #(
   parameter int unsigned DATA_WIDTH = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_type,
   input  wire logic signed [sdm_pkg::OUT_W-1:0]   req_dividend,
   input  wire logic signed [sdm_pkg::OUT_W-1:0]   req_divisor,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [sdm_pkg::OUT_W-1:0]        rsp_result_value,
   output logic                                    rsp_range_error
);

   logic                   adv;
   logic                   c_valid [DATA_WIDTH+1];
   sdm_pkg::sdm_flags_type c_flags [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0]  c_rem   [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0]  c_dq    [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0]  c_mb    [DATA_WIDTH+1];

   assign req_stall = !adv;
   assign c_rem[0]  = {DATA_WIDTH{1'b0}};

   sdm_prep #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_prep (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .in_type     (req_type),
      .in_dividend (req_dividend),
      .in_divisor  (req_divisor),
      .out_valid   (c_valid[0]),
      .out_flags   (c_flags[0]),
      .out_ma      (c_dq[0]),
      .out_mb      (c_mb[0])
   );

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      sdm_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (c_valid[i]),
         .in_flags  (c_flags[i]),
         .in_rem    (c_rem[i]),
         .in_dq     (c_dq[i]),
         .in_mb     (c_mb[i]),
         .out_valid (c_valid[i+1]),
         .out_flags (c_flags[i+1]),
         .out_rem   (c_rem[i+1]),
         .out_dq    (c_dq[i+1]),
         .out_mb    (c_mb[i+1])
      );
   end

   sdm_post #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_post (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (c_valid[DATA_WIDTH]),
      .in_flags         (c_flags[DATA_WIDTH]),
      .in_rem           (c_rem[DATA_WIDTH]),
      .in_quo           (c_dq[DATA_WIDTH]),
      .rsp_stall        (rsp_stall),
      .adv              (adv),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_range_error  (rsp_range_error)
   );

endmodule

`default_nettype wire

// File: sim/signed_div_mod_64_checked_top_test.sv
// signed_div_mod_64_checked_top_test: self-checking bench for the signed divide / remainder
// directed sign, error and extreme cases, random two-sided idling, full rate, rsp stalls
// depends on sdm_pkg and signed_div_mod_64_checked_top
`timescale 1ns / 1ps

module signed_div_mod_64_checked_top_test;

   localparam int W = 64;
   localparam int IDLE_LIMIT = 4000;
   localparam logic signed [63:0] MOST_NEG = -(64'sd1 <<< (W - 1));
   localparam logic signed [63:0] MOST_POS = (64'sd1 <<< (W - 1)) - 64'sd1;
   localparam logic signed [63:0] MINUS_ONE = -64'sd1;

   typedef struct packed {
      logic signed [63:0] value;
      logic               range_err;
   } div_answer_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic                             req_type = sdm_pkg::REQ_QUOT;
   logic signed [sdm_pkg::OUT_W-1:0] req_dividend = '0;
   logic signed [sdm_pkg::OUT_W-1:0] req_divisor = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic signed [sdm_pkg::OUT_W-1:0] rsp_result_value;
   logic                             rsp_range_error;

   div_answer_type awaited_answers[$];
   int fail_count = 0;
   int gap_max = 9;
   int stall_max = 9;
   int stall_left = 0;

   signed_div_mod_64_checked_top #(.DATA_WIDTH(W)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_dividend     (req_dividend),
      .req_divisor      (req_divisor),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_range_error  (rsp_range_error)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic div_answer_type div_mod_answer(input logic kind, input logic [63:0] num,
                                                     input logic [63:0] den);
      div_answer_type ans;
      logic [W-1:0] a;
      logic [W-1:0] b;
      logic [W-1:0] mag_a;
      logic [W-1:0] mag_b;
      logic [W-1:0] quo;
      logic [W-1:0] rem;
      logic signed [W-1:0] res;
      logic neg_a;
      logic neg_b;
      a = num[W-1:0];
      b = den[W-1:0];
      neg_a = a[W-1];
      neg_b = b[W-1];
      if (b == '0 || (a == {1'b1, {(W - 1){1'b0}}} && b == '1)) begin
         ans.value = '0;
         ans.range_err = 1'b1;
      end else begin
         mag_a = neg_a ? -a : a;
         mag_b = neg_b ? -b : b;
         quo = mag_a / mag_b;
         rem = mag_a % mag_b;
         if (kind == sdm_pkg::REQ_REM) begin
            res = neg_a ? -rem : rem;
         end else begin
            res = (neg_a != neg_b) ? -quo : quo;
         end
         ans.value = res;
         ans.range_err = 1'b0;
      end
      return ans;
   endfunction

   function automatic logic [63:0] pick_operand();
      logic [63:0] v;
      case ($urandom_range(0, 7))
         0, 1, 2: v = {$urandom, $urandom};
         3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
         4: v = 64'($urandom_range(0, 300));
         5: v = 64'd1 << $urandom_range(0, 63);
         6: v = MOST_NEG + 64'($urandom_range(0, 3));
         default: v = MOST_POS - 64'($urandom_range(0, 3));
      endcase
      if ($urandom_range(0, 1)) begin
         v = -v;
      end
      return v;
   endfunction

   function automatic logic pick_kind();
      return $urandom_range(0, 1) ? sdm_pkg::REQ_REM : sdm_pkg::REQ_QUOT;
   endfunction

   task automatic send_request(input logic kind, input logic [63:0] num, input logic [63:0] den);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_dividend <= num;
      req_divisor <= den;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_answers.push_back(div_mod_answer(kind, num, den));
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string field, input logic signed [63:0] want,
                                  input logic signed [63:0] got);
      fail_count++;
      $error("%s: expected %0d, got %0d", field, want, got);
   endtask

   always @(posedge clock) begin
      div_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_answers.size() == 0) begin
            report_mismatch("unexpected response result_value", '0, rsp_result_value);
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_result_value !== want.value) begin
               report_mismatch("result_value", want.value, rsp_result_value);
            end
            if (rsp_range_error !== want.range_err) begin
               report_mismatch("range_error", 64'(want.range_err), 64'(rsp_range_error));
            end
         end
         stall_left = $urandom_range(0, stall_max);
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("signed_div_mod_64_checked_top verification failed");
      $finish;
   end

   task automatic test_sign_combinations();
      send_request(sdm_pkg::REQ_QUOT, 64'sd7, 64'sd2);
      send_request(sdm_pkg::REQ_REM, 64'sd7, 64'sd2);
      send_request(sdm_pkg::REQ_QUOT, -64'sd7, 64'sd2);
      send_request(sdm_pkg::REQ_REM, -64'sd7, 64'sd2);
      send_request(sdm_pkg::REQ_QUOT, 64'sd7, -64'sd2);
      send_request(sdm_pkg::REQ_REM, 64'sd7, -64'sd2);
      send_request(sdm_pkg::REQ_QUOT, -64'sd7, -64'sd2);
      send_request(sdm_pkg::REQ_REM, -64'sd7, -64'sd2);
   endtask

   task automatic test_error_cases();
      send_request(sdm_pkg::REQ_QUOT, 64'sd5, 64'sd0);
      send_request(sdm_pkg::REQ_REM, -64'sd5, 64'sd0);
      send_request(sdm_pkg::REQ_QUOT, 64'sd0, 64'sd0);
      send_request(sdm_pkg::REQ_QUOT, MOST_NEG, MINUS_ONE);
      send_request(sdm_pkg::REQ_REM, MOST_NEG, MINUS_ONE);
   endtask

   task automatic test_operand_extremes();
      send_request(sdm_pkg::REQ_QUOT, MOST_NEG, 64'sd1);
      send_request(sdm_pkg::REQ_REM, MOST_NEG, 64'sd2);
      send_request(sdm_pkg::REQ_QUOT, MOST_POS, MINUS_ONE);
      send_request(sdm_pkg::REQ_QUOT, MOST_POS, MOST_NEG);
      send_request(sdm_pkg::REQ_REM, MOST_POS, MOST_NEG);
      send_request(sdm_pkg::REQ_QUOT, MOST_NEG, MOST_POS);
      send_request(sdm_pkg::REQ_REM, MOST_NEG, MOST_POS);
      send_request(sdm_pkg::REQ_REM, 64'sd0, MOST_NEG);
      send_request(sdm_pkg::REQ_QUOT, MOST_NEG, MOST_NEG);
      send_request(sdm_pkg::REQ_REM, 64'sd1, MOST_POS);
      send_request(sdm_pkg::REQ_REM, MOST_POS, 64'sd3);
   endtask

   task automatic test_random_mix(input int count);
      logic [63:0] num;
      logic [63:0] den;
      int roll;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            roll = $urandom_range(0, 3);
            gap_max = (roll == 1 || roll == 3) ? 9 : 0;
            stall_max = (roll >= 2) ? 9 : 0;
         end
         if (i == count / 2) begin
            wait_for_drain();
         end
         num = pick_operand();
         den = pick_operand();
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            den = '0;
         end else if (roll < 7) begin
            num = MOST_NEG;
            den = MINUS_ONE;
         end else if (roll < 12) begin
            den = roll[0] ? MINUS_ONE : 64'sd1;
         end
         send_request(pick_kind(), num, den);
      end
   endtask

   task automatic test_full_rate(input int count);
      gap_max = 0;
      stall_max = 0;
      for (int i = 0; i < count; i++) begin
         send_request(pick_kind(), pick_operand(), pick_operand());
      end
   endtask

   task automatic test_response_backpressure(input int count);
      gap_max = 0;
      stall_max = 9;
      for (int i = 0; i < count; i++) begin
         send_request(pick_kind(), pick_operand(), pick_operand());
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_sign_combinations();
      test_error_cases();
      test_operand_extremes();
      wait_for_drain();
      test_random_mix(1400);
      test_full_rate(150);
      test_response_backpressure(130);
      gap_max = 9;
      stall_max = 9;
      wait_for_drain();
      repeat (W + 5) @(posedge clock);
      if (fail_count == 0 && awaited_answers.size() == 0) begin
         $display("signed_div_mod_64_checked_top verification clean");
      end else begin
         $display("signed_div_mod_64_checked_top verification failed");
      end
      $finish;
   end

endmodule

// File: signed_div_mod_64_checked_top.f
sv/sdm_pkg.sv
sv/sdm_prep.sv
sv/sdm_cell.sv
sv/sdm_post.sv
sv/signed_div_mod_64_checked_top.sv
sim/signed_div_mod_64_checked_top_test.sv
